[design/wildcard_glob_matcher_defines.svh]
// Assertion macros shared by the checker of the wildcard glob matcher.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WGM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define WGM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/wgm_pkg.sv]
// Package of the wildcard glob matcher: sizes, character codes, register
// indexes and the control bundle broadcast to the cell row. No dependencies.
package wgm_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int LEN_W       = 6;
	localparam int CHAR_W      = 8;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int PAT_WORDS   = 4;

	localparam logic [CHAR_W-1:0] STAR_CODE  = 8'h2A;
	localparam logic [CHAR_W-1:0] QMARK_CODE = 8'h3F;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAT0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 3'd4;

	// Request mode codes
	localparam logic MODE_CHAR = 1'b0;
	localparam logic MODE_END  = 1'b1;

	// Control broadcast to every cell
	typedef struct packed {
		logic              step;      // character request taken: advance
		logic              restart;   // end request taken: back to start
		logic [CHAR_W-1:0] char_code;
	} cell_ctrl_t;

endpackage

[design/wgm_if.sv]
// Valid/ready channel interfaces of the wildcard glob matcher.
// Depends on wgm_pkg for field widths.
interface wgm_req_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [wgm_pkg::CHAR_W-1:0] char_code;

	modport source (output valid, output mode, output char_code, input ready);
	modport sink   (input valid, input mode, input char_code, output ready);
endinterface

interface wgm_res_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink   (input valid, input matched, output ready);
endinterface

[design/wildcard_glob_matcher.sv]
// Wildcard glob matcher top level: configuration registers, row of wgm_cell
// instances and result register. Depends on wgm_pkg, wgm_if and wgm_cell.
//
// Usage:
//   subject : request channel; mode 0 carries one subject byte in char_code,
//             mode 1 ends the string (char_code ignored).
//   result  : one item per end request, matched = 1 when the whole subject
//             fits the pattern ('*' any run, '?' any byte, others literal).
//   cfg     : write port; index 0..3 load pattern bytes 0..31 eight at a
//             time (lowest byte first), index 4 the pattern length (values
//             above 32 act as 32). Write only while the block is idle.
// Timing: one request per cycle unless stalled; the active set of all 33
//   positions updates in the cycle a byte is taken. The result is registered
//   in the cycle after its end request. The star closure ripples through the
//   cell row, so the path grows with pattern length like a carry chain.
// Reset: pattern and length clear, only position zero is active.
// Stall: a waiting result holds; subject.ready drops only while a result
//   waits and the result channel is not ready.
module wildcard_glob_matcher (
	input  logic                          clk,
	input  logic                          arst_n,
	wgm_req_if.sink                       subject,
	wgm_res_if.source                     result,
	input  logic                          cfg_we,
	input  logic [wgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wgm_pkg::CFG_W-1:0]     cfg_data
);

	localparam int NP = wgm_pkg::MAX_PATTERN;

	logic [wgm_pkg::CFG_W-1:0] pat_q [wgm_pkg::PAT_WORDS];
	logic [wgm_pkg::LEN_W-1:0] len_q;
	logic [wgm_pkg::LEN_W-1:0] eff_len;
	logic                      top_q;
	logic                      res_valid_q;
	logic                      res_matched_q;
	logic                      req_take;
	wgm_pkg::cell_ctrl_t       ctrl;
	logic [NP:0]               skip;
	logic [NP:0]               adv;
	logic [NP:0]               closed;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < wgm_pkg::PAT_WORDS; w++) begin
				pat_q[w] <= '0;
			end
			len_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				wgm_pkg::CFG_PAT0, wgm_pkg::CFG_PAT1,
				wgm_pkg::CFG_PAT2, wgm_pkg::CFG_PAT3: begin
					pat_q[cfg_index[1:0]] <= cfg_data;
				end
				wgm_pkg::CFG_LEN: begin
					len_q <= cfg_data[wgm_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp length to the row size
	assign eff_len = (len_q > wgm_pkg::LEN_W'(NP)) ? wgm_pkg::LEN_W'(NP) : len_q;

	// Handshake and cell control
	assign subject.ready  = !res_valid_q || result.ready;
	assign req_take       = subject.valid && subject.ready;
	assign ctrl.step      = req_take && (subject.mode == wgm_pkg::MODE_CHAR);
	assign ctrl.restart   = req_take && (subject.mode == wgm_pkg::MODE_END);
	assign ctrl.char_code = subject.char_code;

	assign skip[0] = 1'b0;
	assign adv[0]  = 1'b0;

	// Cell row, one per pattern position
	for (genvar i = 0; i < NP; i++) begin : g_cell
		wgm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.init_val ((i == 0) ? 1'b1 : 1'b0),
			.pat_char (pat_q[i/8][(i%8)*8 +: 8]),
			.in_use   (wgm_pkg::LEN_W'(i) < eff_len),
			.skip_in  (skip[i]),
			.adv_in   (adv[i]),
			.skip_out (skip[i+1]),
			.adv_out  (adv[i+1]),
			.closed   (closed[i])
		);
	end

	// Final position: whole pattern consumed
	assign closed[NP] = top_q | skip[NP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= 1'b0;
		end else if (ctrl.restart) begin
			top_q <= 1'b0;
		end else if (ctrl.step) begin
			top_q <= adv[NP];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.restart) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.restart) begin
			res_matched_q <= closed[eff_len];
		end
	end

	assign result.valid   = res_valid_q;
	assign result.matched = res_matched_q;

endmodule

[design/wgm_cell.sv]
// One pattern position of the matcher: holds its active bit, closes over a
// star and hands the advance and closure signals on. Depends on wgm_pkg.
module wgm_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wgm_pkg::cell_ctrl_t        ctrl,
	input  logic                       init_val,
	input  logic [wgm_pkg::CHAR_W-1:0] pat_char,
	input  logic                       in_use,
	input  logic                       skip_in,
	input  logic                       adv_in,
	output logic                       skip_out,
	output logic                       adv_out,
	output logic                       closed
);

	logic active_q;
	logic is_star;
	logic hit;

	// Closure: a star reached from below is also active here
	assign closed   = active_q | skip_in;
	assign is_star  = (pat_char == wgm_pkg::STAR_CODE);
	assign hit      = (pat_char == wgm_pkg::QMARK_CODE) || (pat_char == ctrl.char_code);
	assign skip_out = closed & in_use & is_star;
	assign adv_out  = closed & in_use & !is_star & hit;

	// Star keeps itself; others are fed by the cell below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= init_val;
		end else if (ctrl.restart) begin
			active_q <= init_val;
		end else if (ctrl.step) begin
			active_q <= skip_out | adv_in;
		end
	end

endmodule

[design/wgm_checker.sv]
// Port-level checker of the wildcard glob matcher, bound to the top level.
// Depends on wildcard_glob_matcher_defines.svh.
`include "wildcard_glob_matcher_defines.svh"

module wgm_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic req_mode,
	input logic res_valid,
	input logic res_ready,
	input logic res_matched
);

	// A waiting result stays and keeps its value
	`WGM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_matched), "result dropped or changed while stalled")

	// A new result only follows an end request
	`WGM_ASSERT_NEXT(a_res_cause, !res_valid, !res_valid || $past(req_valid && req_ready && req_mode), "result without end request")

	// Requests are held back while a result waits unaccepted
	`WGM_ASSERT_NOW(a_backpressure, res_valid && !res_ready, !req_ready, "request taken while result stalled")

	// A character request never produces a result
	`WGM_ASSERT_NEXT(a_char_silent, req_valid && req_ready && !req_mode && !res_valid, !res_valid, "result after character request")

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (subject.valid),
	.req_ready   (subject.ready),
	.req_mode    (subject.mode),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_matched (result.matched)
);

[tb/tb_top.sv]
// Self-checking bench for wildcard_glob_matcher: directed and random subject
// strings against changing patterns, with a bit-parallel predictor in a class.
// Depends on wgm_pkg, wgm_if and the block itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Tracks the pattern, the live position set and the pending match flags
	class glob_match_tracker;
		logic [wgm_pkg::CFG_W-1:0]     pat_words [wgm_pkg::PAT_WORDS];
		logic [wgm_pkg::LEN_W-1:0]     pat_len;
		logic [wgm_pkg::MAX_PATTERN:0] live_set;
		logic                          expected_matches [$];
		int                            errors;

		function new();
			foreach (pat_words[i]) pat_words[i] = '0;
			pat_len  = '0;
			live_set = (wgm_pkg::MAX_PATTERN + 1)'(1);
			errors   = 0;
		endfunction

		function void write_reg(logic [wgm_pkg::CFG_IDX_W-1:0] idx,
			logic [wgm_pkg::CFG_W-1:0] data);
			case (idx)
				wgm_pkg::CFG_PAT0: pat_words[0] = data;
				wgm_pkg::CFG_PAT1: pat_words[1] = data;
				wgm_pkg::CFG_PAT2: pat_words[2] = data;
				wgm_pkg::CFG_PAT3: pat_words[3] = data;
				wgm_pkg::CFG_LEN:  pat_len = data[wgm_pkg::LEN_W-1:0];
				default:  ;
			endcase
		endfunction

		// lengths above the row size saturate
		function logic [wgm_pkg::LEN_W-1:0] span();
			return (pat_len > wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN)) ?
				wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN) : pat_len;
		endfunction

		function logic [wgm_pkg::CHAR_W-1:0] pat_char(logic [4:0] k);
			return pat_words[k[4:3]][{k[2:0], 3'b000} +: wgm_pkg::CHAR_W];
		endfunction

		// a live position on a star may also skip it; ripples upwards
		function logic [wgm_pkg::MAX_PATTERN:0] star_closure(
			logic [wgm_pkg::MAX_PATTERN:0] s, logic [wgm_pkg::LEN_W-1:0] n);
			for (int i = 0; i < int'(n); i++)
				if (s[i[5:0]] && pat_char(i[4:0]) == wgm_pkg::STAR_CODE)
					s[i[5:0] + 6'd1] = 1'b1;
			return s;
		endfunction

		function void note_request(logic m, logic [wgm_pkg::CHAR_W-1:0] c);
			logic [wgm_pkg::LEN_W-1:0]     n;
			logic [wgm_pkg::MAX_PATTERN:0] cur;
			logic [wgm_pkg::MAX_PATTERN:0] nxt;
			logic [wgm_pkg::CHAR_W-1:0]    p;
			n   = span();
			cur = star_closure(live_set, n);
			nxt = '0;
			if (m == wgm_pkg::MODE_END) begin
				expected_matches = {expected_matches, cur[n]};
				live_set = (wgm_pkg::MAX_PATTERN + 1)'(1);
			end else begin
				for (int i = 0; i < int'(n); i++) begin
					p = pat_char(i[4:0]);
					if (!cur[i[5:0]]) continue;
					if (p == wgm_pkg::STAR_CODE) nxt[i[5:0]] = 1'b1;
					else if (p == wgm_pkg::QMARK_CODE || p == c) nxt[i[5:0] + 6'd1] = 1'b1;
				end
				live_set = nxt;
			end
		endfunction

		function void check_result(logic matched);
			logic want;
			if (expected_matches.size() == 0) begin
				$error("matched: expected none, actual %0b", matched);
				errors++;
				return;
			end
			want = expected_matches.pop_front();
			if (matched !== want) begin
				$error("matched: expected %0b, actual %0b", want, matched);
				errors++;
			end
		endfunction

		function int pending();
			return expected_matches.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we;
	logic [wgm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [wgm_pkg::CFG_W-1:0]     cfg_data;

	wgm_req_if subject_if ();
	wgm_res_if result_if ();

	wildcard_glob_matcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.subject   (subject_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	glob_match_tracker tracker = new();

	logic [wgm_pkg::CFG_W-1:0] pat_img [wgm_pkg::PAT_WORDS];
	logic [wgm_pkg::LEN_W-1:0] pat_len_img;
	int                        snd_idle_pct = 8;
	int                        rcv_idle_pct = 48;
	bit                        random_on = 1'b0;
	int                        random_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// Result side: random back-pressure, check every accepted result
	initial begin
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_if.valid && result_if.ready) tracker.check_result(result_if.matched);
			result_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	task automatic write_reg(input logic [wgm_pkg::CFG_IDX_W-1:0] idx,
		input logic [wgm_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	task automatic load_pattern();
		write_reg(wgm_pkg::CFG_PAT0, pat_img[0]);
		write_reg(wgm_pkg::CFG_PAT1, pat_img[1]);
		write_reg(wgm_pkg::CFG_PAT2, pat_img[2]);
		write_reg(wgm_pkg::CFG_PAT3, pat_img[3]);
		write_reg(wgm_pkg::CFG_LEN, wgm_pkg::CFG_W'(pat_len_img));
		cfg_we <= 1'b0;
	endtask

	task automatic set_pattern_text(input string s, input int len_val);
		foreach (pat_img[i]) pat_img[i] = '0;
		for (int i = 0; i < s.len(); i++)
			pat_img[i[4:3]][{i[2:0], 3'b000} +: wgm_pkg::CHAR_W] = s[i];
		pat_len_img = wgm_pkg::LEN_W'(len_val);
		load_pattern();
	endtask

	// One request; idle cycles first at the set rate, valid left high after acceptance
	task automatic send_req(input logic m, input logic [wgm_pkg::CHAR_W-1:0] c);
		if (random_on) begin
			if (random_count < 233) begin
				snd_idle_pct = 8;
				rcv_idle_pct = 48;
			end else if (random_count < 466) begin
				snd_idle_pct = 48;
				rcv_idle_pct = 8;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
		end
		// each idle cycle drawn on its own
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			subject_if.valid <= 1'b0;
			@(posedge clk);
		end
		subject_if.valid     <= 1'b1;
		subject_if.mode      <= m;
		subject_if.char_code <= c;
		do @(posedge clk); while (!subject_if.ready);
		tracker.note_request(m, c);
		if (random_on) random_count++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_req(wgm_pkg::MODE_CHAR, s[i]);
		send_req(wgm_pkg::MODE_END, wgm_pkg::CHAR_W'($urandom_range(0, 255)));
	endtask

	// Hold the sender until every result is back, then let the pipe empty
	task automatic settle();
		subject_if.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly a tiny alphabet with some pattern metacharacters, sometimes any byte
	function automatic logic [wgm_pkg::CHAR_W-1:0] glob_byte(bit with_meta);
		int r;
		string alpha;
		alpha = with_meta ? "**??abcab" : "abc*?abca";
		r = $urandom_range(0, 9);
		if (r == 9) return wgm_pkg::CHAR_W'($urandom_range(0, 255));
		return alpha[r];
	endfunction

	task automatic make_subject(ref logic [wgm_pkg::CHAR_W-1:0] q [$]);
		int                         n;
		int                         pos;
		logic [wgm_pkg::CHAR_W-1:0] b;
		q.delete();
		n = (pat_len_img > wgm_pkg::MAX_PATTERN) ? wgm_pkg::MAX_PATTERN : int'(pat_len_img);
		if ($urandom_range(0, 99) < 20) begin
			// noise string
			repeat ($urandom_range(0, 8)) q = {q, glob_byte(1'b0)};
			return;
		end
		for (int k = 0; k < n; k++) begin
			b = pat_img[k[4:3]][{k[2:0], 3'b000} +: wgm_pkg::CHAR_W];
			if (b == wgm_pkg::STAR_CODE) repeat ($urandom_range(0, 3)) q = {q, glob_byte(1'b0)};
			else if (b == wgm_pkg::QMARK_CODE) q = {q, glob_byte(1'b0)};
			else q = {q, b};
		end
		// occasional damage to a well-formed subject
		if ($urandom_range(0, 99) < 25) begin
			pos = (q.size() > 0) ? $urandom_range(0, q.size() - 1) : 0;
			case ($urandom_range(0, 2))
				0: if (q.size() > 0) q.delete(pos);
				1: if (q.size() > 0) q[pos] = glob_byte(1'b0);
				default: q.insert(pos, glob_byte(1'b0));
			endcase
		end
	endtask

	task automatic random_phase();
		int                         r;
		logic [wgm_pkg::CHAR_W-1:0] subj [$];
		for (int k = 0; k < wgm_pkg::MAX_PATTERN; k++)
			pat_img[k[4:3]][{k[2:0], 3'b000} +: wgm_pkg::CHAR_W] = glob_byte(1'b1);
		r = $urandom_range(0, 99);
		if (r < 70) pat_len_img = wgm_pkg::LEN_W'($urandom_range(0, 10));
		else if (r < 85) pat_len_img = wgm_pkg::LEN_W'($urandom_range(11, 31));
		else if (r < 95) pat_len_img = wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN);
		else pat_len_img = wgm_pkg::LEN_W'($urandom_range(wgm_pkg::MAX_PATTERN + 1, 63));
		load_pattern();
		repeat ($urandom_range(3, 10)) begin
			if (random_count >= 700) break;
			make_subject(subj);
			foreach (subj[i]) send_req(wgm_pkg::MODE_CHAR, subj[i]);
			send_req(wgm_pkg::MODE_END, wgm_pkg::CHAR_W'($urandom_range(0, 255)));
		end
		settle();
	endtask

	initial begin
		subject_if.valid     = 1'b0;
		subject_if.mode      = wgm_pkg::MODE_CHAR;
		subject_if.char_code = '0;
		cfg_we               = 1'b0;
		cfg_index            = wgm_pkg::CFG_PAT0;
		cfg_data             = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern straight from reset
		send_text("");
		send_text("a");
		settle();

		// lone star, also against a star in the subject
		set_pattern_text("*", 1);
		send_text("*");
		send_text("");
		send_text("x");
		settle();

		set_pattern_text("a?c", 3);
		send_text("abc");
		send_text("ac");
		send_text("a*c");
		settle();

		// stars everywhere, oversized length saturates
		foreach (pat_img[i]) pat_img[i] = {8{wgm_pkg::STAR_CODE}};
		pat_len_img = '1;
		load_pattern();
		send_text("");
		send_req(wgm_pkg::MODE_CHAR, '1);
		send_req(wgm_pkg::MODE_END, '1);
		send_req(wgm_pkg::MODE_CHAR, '0);
		send_req(wgm_pkg::MODE_END, '0);
		settle();

		foreach (pat_img[i]) pat_img[i] = '1;
		pat_len_img = wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN);
		load_pattern();
		send_req(wgm_pkg::MODE_CHAR, '1);
		send_req(wgm_pkg::MODE_END, '0);
		settle();

		// pattern swapped in the middle of a string
		set_pattern_text("ab", 2);
		send_req(wgm_pkg::MODE_CHAR, "a");
		settle();
		set_pattern_text("a?", 2);
		send_text("z");
		settle();

		random_on = 1'b1;
		while (random_count < 700) random_phase();
		repeat (8) @(posedge clk);

		if (tracker.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/wgm_pkg.sv
design/wgm_if.sv
design/wgm_cell.sv
design/wildcard_glob_matcher.sv
design/wgm_checker.sv
tb/tb_top.sv
